### hw/rtl/tlbpt_pkg.sv
// Shared types, sizes and helper functions for the TLB page table translator.
package tlbpt_pkg;

   localparam int TLB_ENTRIES = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int FRAME_COUNT = 256;

   localparam int VA_W      = 16;
   localparam int OFFSET_W  = 8;
   localparam int RAW_PAGE_W = VA_W - OFFSET_W;
   localparam int FRAME_OUT_W = 8;
   localparam int CNT_W     = 32;

   localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
   localparam int PAGE_W    = $clog2(PAGE_COUNT);
   localparam int FRAME_W   = $clog2(FRAME_COUNT);
   localparam int NFF_W     = $clog2(FRAME_COUNT + 1);
   localparam int RAW_PAGES = 1 << RAW_PAGE_W;

   typedef enum logic {
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   typedef struct packed {
      logic capture;
      logic resolve;
   } ctrl_cmd_type;

   typedef logic [PAGE_W-1:0] wrap_table_type [RAW_PAGES];

   // Page number folded into the page table range, one entry per raw page.
   function automatic wrap_table_type build_wrap();
      wrap_table_type t;
      for (int i = 0; i < RAW_PAGES; i++) begin
         t[i] = PAGE_W'(i % PAGE_COUNT);
      end
      return t;
   endfunction

   localparam wrap_table_type PAGE_WRAP_TABLE = build_wrap();

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
   endfunction

endpackage

### hw/rtl/tlb_page_table_translator_unit.sv
// Top level of the demand-paging translator with a FIFO-replaced TLB.
//
// Each accepted word is a 16-bit virtual address (page in bits 15..8, offset in
// bits 7..0). The cycle in which start is taken reads the page table memory,
// and the following cycle (busy high) searches all TLB entries in parallel,
// picks the frame from the TLB, the page table or the free-frame counter, and
// writes back the TLB slot under the FIFO pointer, the page table entry and
// the counters. The result word is on the rsp_ ports, marked by rsp_valid for
// exactly one cycle, in the first cycle with busy low; a new start is taken
// in that same cycle. The receiver cannot stall: sample the result whenever
// rsp_valid is high. When a fault finds no free frame, rsp_no_frame is set,
// the address and frame read zero and no state changes. The three totals
// saturate at all ones. No clearing pass is needed after reset; the first
// start may come in the cycle after reset drops.
module tlb_page_table_translator_unit
   import tlbpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VA_W-1:0]        req_virt_addr,
   output logic                   rsp_valid,
   output logic [VA_W-1:0]        rsp_paddr,
   output logic [FRAME_OUT_W-1:0] rsp_frame_num,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_fault_taken,
   output logic                   rsp_no_frame,
   output logic [CNT_W-1:0]       rsp_tlb_hit_total,
   output logic [CNT_W-1:0]       rsp_table_hit_total,
   output logic [CNT_W-1:0]       rsp_access_total
);

   // commands from the sequencer to the datapath
   ctrl_cmd_type cmd;

   tlbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   tlbpt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_virt_addr       (req_virt_addr),
      .rsp_paddr           (rsp_paddr),
      .rsp_frame_num       (rsp_frame_num),
      .rsp_tlb_hit         (rsp_tlb_hit),
      .rsp_fault_taken     (rsp_fault_taken),
      .rsp_no_frame        (rsp_no_frame),
      .rsp_tlb_hit_total   (rsp_tlb_hit_total),
      .rsp_table_hit_total (rsp_table_hit_total),
      .rsp_access_total    (rsp_access_total)
   );

endmodule

### hw/rtl/tlbpt_ctrl.sv
// Sequencer for the translator: accept, resolve, strobe the result.
module tlbpt_ctrl
   import tlbpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd,
   output logic         rsp_valid
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy         = 1'b0;
      cmd.capture  = 1'b0;
      cmd.resolve  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_RESOLVE: begin
            busy        = 1'b1;
            cmd.resolve = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
      rsp_valid_in = cmd.resolve;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_resolve_strobes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |=> rsp_valid_ff)
      else $error("resolve cycle not followed by a result strobe");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while a translation is in flight");

endmodule

### hw/rtl/tlbpt_datapath.sv
// TLB, page table, frame allocator and counters for the translator.
module tlbpt_datapath
   import tlbpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   input  logic [VA_W-1:0]        req_virt_addr,
   output logic [VA_W-1:0]        rsp_paddr,
   output logic [FRAME_OUT_W-1:0] rsp_frame_num,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_fault_taken,
   output logic                   rsp_no_frame,
   output logic [CNT_W-1:0]       rsp_tlb_hit_total,
   output logic [CNT_W-1:0]       rsp_table_hit_total,
   output logic [CNT_W-1:0]       rsp_access_total
);

   // captured request
   logic [PAGE_W-1:0]   page_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [PAGE_W-1:0]   page_in;

   // TLB
   logic [PAGE_W-1:0]    tlb_tag_ff   [TLB_ENTRIES];
   logic [FRAME_W-1:0]   tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [TLB_IDX_W-1:0] fifo_ptr_ff;

   // page table
   logic [FRAME_W-1:0]    table_mem [PAGE_COUNT];
   logic [FRAME_W-1:0]    table_rd_ff;
   logic [PAGE_COUNT-1:0] table_valid_ff;

   logic [NFF_W-1:0] next_free_ff;
   logic [CNT_W-1:0] tlb_cnt_ff, table_cnt_ff, access_cnt_ff;

   // result registers
   logic [VA_W-1:0]        phys_ff;
   logic [FRAME_OUT_W-1:0] frame_out_ff;
   logic                   hit_ff, fault_ff, none_ff;

   // resolve logic
   logic [TLB_ENTRIES-1:0] match;
   logic [TLB_IDX_W-1:0]   found_idx;
   logic                   tlb_hit;
   logic                   tbl_valid;
   logic                   frames_left;
   logic                   fault, none, fill;
   logic [FRAME_W-1:0]     frame_sel;

   assign page_in = PAGE_WRAP_TABLE[req_virt_addr[VA_W-1:OFFSET_W]];

   always_comb begin
      found_idx = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         match[i] = tlb_valid_ff[i] && (tlb_tag_ff[i] == page_ff);
      end
      // lowest matching entry wins
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) found_idx = TLB_IDX_W'(i);
      end
      tlb_hit     = |match;
      tbl_valid   = table_valid_ff[page_ff];
      frames_left = (next_free_ff < NFF_W'(FRAME_COUNT));
      fault       = !tlb_hit && !tbl_valid && frames_left;
      none        = !tlb_hit && !tbl_valid && !frames_left;
      fill        = !tlb_hit && !none;
      if (tlb_hit) begin
         frame_sel = tlb_frame_ff[found_idx];
      end else if (tbl_valid) begin
         frame_sel = table_rd_ff;
      end else if (frames_left) begin
         frame_sel = next_free_ff[FRAME_W-1:0];
      end else begin
         frame_sel = '0;
      end
   end

   // capture the request and start the page table read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff     <= page_in;
         offset_ff   <= req_virt_addr[OFFSET_W-1:0];
         table_rd_ff <= table_mem[page_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve && fault) begin
         table_mem[page_ff] <= frame_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve && fill) begin
         tlb_tag_ff[fifo_ptr_ff]   <= page_ff;
         tlb_frame_ff[fifo_ptr_ff] <= frame_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         phys_ff      <= none ? '0 : {FRAME_OUT_W'(frame_sel), offset_ff};
         frame_out_ff <= FRAME_OUT_W'(frame_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff   <= '0;
         fifo_ptr_ff    <= '0;
         table_valid_ff <= '0;
         next_free_ff   <= '0;
         tlb_cnt_ff     <= '0;
         table_cnt_ff   <= '0;
         access_cnt_ff  <= '0;
         hit_ff         <= 1'b0;
         fault_ff       <= 1'b0;
         none_ff        <= 1'b0;
      end else if (cmd.resolve) begin
         hit_ff   <= tlb_hit;
         fault_ff <= fault;
         none_ff  <= none;
         if (tlb_hit) begin
            tlb_cnt_ff <= sat_inc(tlb_cnt_ff);
         end
         if (!tlb_hit && tbl_valid) begin
            table_cnt_ff <= sat_inc(table_cnt_ff);
         end
         if (!none) begin
            access_cnt_ff <= sat_inc(access_cnt_ff);
         end
         if (fault) begin
            table_valid_ff[page_ff] <= 1'b1;
            next_free_ff            <= next_free_ff + NFF_W'(1);
         end
         if (fill) begin
            tlb_valid_ff[fifo_ptr_ff] <= 1'b1;
            fifo_ptr_ff <= (fifo_ptr_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                           '0 : fifo_ptr_ff + TLB_IDX_W'(1);
         end
      end
   end

   assign rsp_paddr           = phys_ff;
   assign rsp_frame_num       = none_ff ? '0 : frame_out_ff;
   assign rsp_tlb_hit         = hit_ff;
   assign rsp_fault_taken     = fault_ff;
   assign rsp_no_frame        = none_ff;
   assign rsp_tlb_hit_total   = tlb_cnt_ff;
   assign rsp_table_hit_total = table_cnt_ff;
   assign rsp_access_total    = access_cnt_ff;

   a_access_covers_tlb: assert property (@(posedge clock) disable iff (reset)
      (access_cnt_ff >= tlb_cnt_ff) && (access_cnt_ff >= table_cnt_ff))
      else $error("access count fell behind a hit count");

   a_frame_limit: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NFF_W'(FRAME_COUNT))
      else $error("frame allocator ran past the frame count");

   a_fault_allocates: assert property (@(posedge clock) disable iff (reset)
      (cmd.resolve && fault) |=> (next_free_ff == $past(next_free_ff) + NFF_W'(1)))
      else $error("page fault did not take a frame");

   a_no_frame_flags: assert property (@(posedge clock) disable iff (reset)
      none_ff |-> (!hit_ff && !fault_ff))
      else $error("no-frame result carries hit or fault flag");

endmodule
